// ----- design/rfae_pkg.sv -----
package rfae_pkg;

    typedef enum logic [3:0] {
        CMD_LOAD = 4'd0,
        CMD_OUT  = 4'd1,
        CMD_MOVE = 4'd2,
        CMD_XCHG = 4'd3,
        CMD_ADD  = 4'd4,
        CMD_SUB  = 4'd5,
        CMD_MUL  = 4'd6,
        CMD_DIV  = 4'd7,
        CMD_MOD  = 4'd8,
        CMD_AND  = 4'd9,
        CMD_OR   = 4'd10,
        CMD_XOR  = 4'd11
    } cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_RD1,
        ST_RD2,
        ST_EXEC,
        ST_DIV,
        ST_WB1,
        ST_WB2,
        ST_OUT
    } state_t;

    localparam int CMD_W  = 4;
    localparam int IDX_W  = 5;
    localparam int IMM_W  = 32;
    localparam int OUT_W  = 32;
    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_DIV0  = 1'b1;

endpackage

// ----- design/rfae_bank.sv -----
module rfae_bank #(
    parameter int NUM_REGS   = 26,
    parameter int DATA_WIDTH = 32
) (
    input  logic                        aclk,
    input  logic                        we,
    input  logic [$clog2(NUM_REGS)-1:0] waddr,
    input  logic [DATA_WIDTH-1:0]       wdata,
    input  logic [$clog2(NUM_REGS)-1:0] raddr,
    output logic [DATA_WIDTH-1:0]       rdata
);
    logic [DATA_WIDTH-1:0] mem [NUM_REGS];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ----- design/rfae_div.sv -----
module rfae_div #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [DATA_WIDTH-1:0] dividend,
    input  logic [DATA_WIDTH-1:0] divisor,
    input  logic                  want_rem,
    output logic                  done,
    output logic [DATA_WIDTH-1:0] result
);
    localparam int CNT_W = $clog2(DATA_WIDTH + 1);

    logic [DATA_WIDTH-1:0] quo_reg, quo_next, den_reg, den_next;
    logic [DATA_WIDTH:0]   rem_reg, rem_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  busy_reg, busy_next, neg_reg, neg_next, rem_sel_reg, rem_sel_next;
    logic [DATA_WIDTH:0]   shifted, diff;
    logic [DATA_WIDTH-1:0] mag_a, mag_b, raw;

    assign mag_a = dividend[DATA_WIDTH-1] ? -dividend : dividend;
    assign mag_b = divisor[DATA_WIDTH-1] ? -divisor : divisor;
    assign shifted = {rem_reg[DATA_WIDTH-1:0], quo_reg[DATA_WIDTH-1]};
    assign diff = shifted - {1'b0, den_reg};

    always_comb begin
        quo_next = quo_reg;
        den_next = den_reg;
        rem_next = rem_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        neg_next = neg_reg;
        rem_sel_next = rem_sel_reg;
        if (start) begin
            quo_next = mag_a;
            den_next = mag_b;
            rem_next = '0;
            cnt_next = CNT_W'(DATA_WIDTH);
            busy_next = 1'b1;
            rem_sel_next = want_rem;
            neg_next = want_rem ? dividend[DATA_WIDTH-1]
                                : (dividend[DATA_WIDTH-1] ^ divisor[DATA_WIDTH-1]);
        end else if (busy_reg) begin
            // one restoring step per cycle
            if (!diff[DATA_WIDTH]) begin
                rem_next = diff;
                quo_next = {quo_reg[DATA_WIDTH-2:0], 1'b1};
            end else begin
                rem_next = shifted;
                quo_next = {quo_reg[DATA_WIDTH-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
        neg_reg <= neg_next;
        rem_sel_reg <= rem_sel_next;
    end

    assign done = busy_reg && (cnt_reg == CNT_W'(1));
    assign raw = rem_sel_reg ? rem_next[DATA_WIDTH-1:0] : quo_next;
    assign result = neg_reg ? -raw : raw;
endmodule

// ----- design/register_file_alu_executor.sv -----
// Executes one decoded instruction per input transfer against a bank of NUM_REGS
// registers held in a synchronous single-port-read memory with a registered read.
// After reset the bank is cleared by a pass over all NUM_REGS registers before
// s_axis_tready rises. An instruction reads its two operands one after the other
// from the memory port. Load goes from the accepted transfer to write-back; the
// other commands read, execute and then write back (exchange writes both registers),
// give a result (out, div/mod by zero) or run the radix-2 restoring divider (div,
// mod) before write-back. Unused codes are dropped in idle. One instruction is in
// flight at a time. Out and a division by zero give one result transfer. A waiting
// result does not block input; an instruction that has its own result to give
// holds in execute until the output register is free.
module register_file_alu_executor #(
    parameter int NUM_REGS   = 26,
    parameter int DATA_WIDTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [3:0] cmd, [8:4] dest_reg, [13:9] src_a_reg, [18:14] src_b_reg,
    // [19] three_operand, [51:20] immediate, [55:52] zero
    input  logic [55:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [31:0] value
    output logic [31:0] m_axis_tdata,
    // [0] status
    output logic        m_axis_tuser
);
    localparam int AW = $clog2(NUM_REGS);

    rfae_pkg::state_t state_reg, state_next;
    logic [rfae_pkg::CMD_W-1:0] cmd_reg, cmd_next;
    logic [rfae_pkg::IDX_W-1:0] d_reg, d_next, a_reg, a_next, b_reg, b_next;
    logic three_reg, three_next;
    logic [rfae_pkg::IMM_W-1:0] imm_reg, imm_next;
    logic [DATA_WIDTH-1:0] x_reg, x_next, y_reg, y_next, r_reg, r_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic ovalid_reg, ovalid_next, ostat_reg, ostat_next;
    logic [31:0] oval_reg, oval_next;
    logic div_go_reg;

    logic we, div_start, div_done;
    logic [AW-1:0] waddr, raddr;
    logic [DATA_WIDTH-1:0] wdata, rdata, div_res, rd_val;
    logic [rfae_pkg::IDX_W-1:0] rd1_idx, rd2_idx, rd_sel;
    logic rd_ok_q, s_fire;
    logic out_due, out_stall;

    rfae_bank #(.NUM_REGS(NUM_REGS), .DATA_WIDTH(DATA_WIDTH)) u_bank (
        .aclk(aclk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
    );

    rfae_div #(.DATA_WIDTH(DATA_WIDTH)) u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start), .dividend(x_reg),
        .divisor(y_reg), .want_rem(cmd_reg == rfae_pkg::CMD_MOD), .done(div_done),
        .result(div_res)
    );

    function automatic logic idx_ok(input logic [rfae_pkg::IDX_W-1:0] i);
        return 32'(i) < NUM_REGS;
    endfunction

    assign s_fire = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == rfae_pkg::ST_IDLE);
    // two-operand form reads dest then srcA; exchange reads dest then srcA as well
    assign rd1_idx = (three_reg && cmd_reg >= rfae_pkg::CMD_ADD) ? a_reg : d_reg;
    assign rd2_idx = (three_reg && cmd_reg >= rfae_pkg::CMD_ADD) ? b_reg : a_reg;
    assign rd_sel = (state_reg == rfae_pkg::ST_RD1) ? rd1_idx : rd2_idx;
    assign rd_val = rd_ok_q ? rdata : '0;

    // out, or div/mod by zero, need the output register
    assign out_due = (cmd_reg == rfae_pkg::CMD_OUT) ||
                     ((cmd_reg == rfae_pkg::CMD_DIV || cmd_reg == rfae_pkg::CMD_MOD) &&
                      rd_val == '0);
    assign out_stall = out_due && ovalid_reg && !m_axis_tready;

    always_ff @(posedge aclk) begin
        rd_ok_q <= idx_ok(rd_sel);
    end

    always_comb begin
        raddr = idx_ok(rd_sel) ? rd_sel[AW-1:0] : '0;
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            rfae_pkg::ST_CLEAR: if (32'(clr_reg) == NUM_REGS - 1) state_next = rfae_pkg::ST_IDLE;
            rfae_pkg::ST_IDLE: begin
                if (s_fire) begin
                    if (s_axis_tdata[3:0] == rfae_pkg::CMD_LOAD) state_next = rfae_pkg::ST_WB1;
                    else if (s_axis_tdata[3:0] > rfae_pkg::CMD_XOR) state_next = rfae_pkg::ST_IDLE;
                    else state_next = rfae_pkg::ST_RD1;
                end
            end
            rfae_pkg::ST_RD1: state_next = rfae_pkg::ST_RD2;
            rfae_pkg::ST_RD2: state_next = rfae_pkg::ST_EXEC;
            rfae_pkg::ST_EXEC: begin
                if (out_stall) begin
                    state_next = rfae_pkg::ST_EXEC;
                end else begin
                    case (cmd_reg)
                        rfae_pkg::CMD_OUT: state_next = rfae_pkg::ST_OUT;
                        rfae_pkg::CMD_DIV, rfae_pkg::CMD_MOD:
                            state_next = (rd_val == '0) ? rfae_pkg::ST_OUT : rfae_pkg::ST_DIV;
                        default: state_next = rfae_pkg::ST_WB1;
                    endcase
                end
            end
            rfae_pkg::ST_DIV: if (div_done) state_next = rfae_pkg::ST_WB1;
            rfae_pkg::ST_WB1: state_next = (cmd_reg == rfae_pkg::CMD_XCHG) ? rfae_pkg::ST_WB2
                                                                         : rfae_pkg::ST_IDLE;
            rfae_pkg::ST_WB2: state_next = rfae_pkg::ST_IDLE;
            rfae_pkg::ST_OUT: state_next = rfae_pkg::ST_IDLE;
            default: state_next = rfae_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cmd_next = cmd_reg; d_next = d_reg; a_next = a_reg; b_next = b_reg;
        three_next = three_reg; imm_next = imm_reg;
        x_next = x_reg; y_next = y_reg; r_next = r_reg;
        clr_next = clr_reg;
        ovalid_next = ovalid_reg; ostat_next = ostat_reg; oval_next = oval_reg;
        we = 1'b0; waddr = '0; wdata = '0;
        if (ovalid_reg && m_axis_tready) ovalid_next = 1'b0;
        case (state_reg)
            rfae_pkg::ST_CLEAR: begin
                we = 1'b1; waddr = clr_reg; wdata = '0;
                clr_next = clr_reg + 1'b1;
            end
            rfae_pkg::ST_IDLE: begin
                if (s_fire) begin
                    cmd_next = s_axis_tdata[3:0];
                    d_next = s_axis_tdata[8:4];
                    a_next = s_axis_tdata[13:9];
                    b_next = s_axis_tdata[18:14];
                    three_next = s_axis_tdata[19];
                    imm_next = s_axis_tdata[51:20];
                    r_next = DATA_WIDTH'($signed(s_axis_tdata[51:20]));
                end
            end
            rfae_pkg::ST_RD2: x_next = rd_val;
            rfae_pkg::ST_EXEC: begin
                y_next = rd_val;
                case (cmd_reg)
                    rfae_pkg::CMD_OUT: begin
                        if (!out_stall) begin
                            ovalid_next = 1'b1; ostat_next = rfae_pkg::STATUS_OK;
                            oval_next = 32'($signed(x_reg));
                        end
                    end
                    rfae_pkg::CMD_MOVE: r_next = rd_val;
                    rfae_pkg::CMD_XCHG: r_next = rd_val;
                    rfae_pkg::CMD_ADD: r_next = x_reg + rd_val;
                    rfae_pkg::CMD_SUB: r_next = x_reg - rd_val;
                    rfae_pkg::CMD_MUL: r_next = DATA_WIDTH'(x_reg * rd_val);
                    rfae_pkg::CMD_AND: r_next = x_reg & rd_val;
                    rfae_pkg::CMD_OR:  r_next = x_reg | rd_val;
                    rfae_pkg::CMD_XOR: r_next = x_reg ^ rd_val;
                    rfae_pkg::CMD_DIV, rfae_pkg::CMD_MOD: begin
                        if (rd_val == '0 && !out_stall) begin
                            ovalid_next = 1'b1; ostat_next = rfae_pkg::STATUS_DIV0;
                            oval_next = '0;
                        end
                    end
                    default: r_next = r_reg;
                endcase
            end
            rfae_pkg::ST_DIV: begin
                if (div_done) r_next = div_res;
            end
            rfae_pkg::ST_WB1: begin
                // exchange writes only when both indexes are in range
                we = idx_ok(d_reg) && (cmd_reg != rfae_pkg::CMD_XCHG || idx_ok(a_reg));
                waddr = d_reg[AW-1:0]; wdata = r_reg;
            end
            rfae_pkg::ST_WB2: begin
                we = idx_ok(d_reg) && idx_ok(a_reg);
                waddr = a_reg[AW-1:0]; wdata = x_reg;
            end
            default: ;
        endcase
    end

    // divider kicks off the cycle after operands land
    always_ff @(posedge aclk) begin
        if (!aresetn) div_go_reg <= 1'b0;
        else div_go_reg <= (state_reg == rfae_pkg::ST_EXEC) && (state_next == rfae_pkg::ST_DIV);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= rfae_pkg::ST_CLEAR;
            clr_reg    <= '0;
            ovalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            clr_reg    <= clr_next;
            ovalid_reg <= ovalid_next;
        end
        cmd_reg <= cmd_next; d_reg <= d_next; a_reg <= a_next; b_reg <= b_next;
        three_reg <= three_next; imm_reg <= imm_next;
        x_reg <= x_next; y_reg <= y_next; r_reg <= r_next;
        ostat_reg <= ostat_next; oval_reg <= oval_next;
    end

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = oval_reg;
    assign m_axis_tuser  = ostat_reg;

    // start comes from the registered flag so y_reg is valid
    assign div_start = div_go_reg;

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != rfae_pkg::ST_IDLE) |-> !s_axis_tready) else $error("accept while busy");
    a_div0_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0)) else $error("div0 value");
    a_no_write_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == rfae_pkg::ST_OUT) |-> !we) else $error("write on out");
    a_imm_used: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == rfae_pkg::ST_WB1 && cmd_reg == rfae_pkg::CMD_LOAD)
        |-> (r_reg == DATA_WIDTH'($signed(imm_reg)))) else $error("load value");
endmodule

// ----- test/register_file_alu_executor_tb.sv -----
module register_file_alu_executor_tb;

    localparam int NREGS = 26;
    localparam int WATCHDOG_LIMIT = 20000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tuser;

    typedef struct packed {
        logic [31:0] value;
        logic        status;
    } result_t;

    logic [31:0] shadow_regs [NREGS];
    result_t     pending_results [$];
    int          fail_count = 0;
    int          idle_pct = 36;
    bit          sink_hold = 1'b0;
    int          quiet_cycles = 0;

    register_file_alu_executor u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic logic [31:0] read_reg(logic [4:0] idx);
        return (idx < NREGS) ? shadow_regs[idx] : 32'd0;
    endfunction

    function automatic void write_reg(logic [4:0] idx, logic [31:0] v);
        if (idx < NREGS) shadow_regs[idx] = v;
    endfunction

    // apply one instruction to the shadow bank; queue a result if one is due
    function automatic void execute_instr(logic [3:0] op, logic [4:0] d, logic [4:0] sa,
                                          logic [4:0] sb, logic three, logic [31:0] imm);
        logic [31:0] x, y, r, t;
        result_t res;
        r = '0;
        case (op)
            rfae_pkg::CMD_LOAD: write_reg(d, imm);
            rfae_pkg::CMD_OUT: begin
                res.value = read_reg(d);
                res.status = rfae_pkg::STATUS_OK;
                pending_results.push_back(res);
            end
            rfae_pkg::CMD_MOVE: write_reg(d, read_reg(sa));
            rfae_pkg::CMD_XCHG: begin
                if (d < NREGS && sa < NREGS) begin
                    t = shadow_regs[d];
                    shadow_regs[d] = shadow_regs[sa];
                    shadow_regs[sa] = t;
                end
            end
            rfae_pkg::CMD_ADD, rfae_pkg::CMD_SUB, rfae_pkg::CMD_MUL, rfae_pkg::CMD_DIV,
            rfae_pkg::CMD_MOD, rfae_pkg::CMD_AND, rfae_pkg::CMD_OR, rfae_pkg::CMD_XOR: begin
                x = three ? read_reg(sa) : read_reg(d);
                y = three ? read_reg(sb) : read_reg(sa);
                if ((op == rfae_pkg::CMD_DIV || op == rfae_pkg::CMD_MOD) && y == 0) begin
                    res.value = '0;
                    res.status = rfae_pkg::STATUS_DIV0;
                    pending_results.push_back(res);
                end else begin
                    case (op)
                        rfae_pkg::CMD_ADD: r = x + y;
                        rfae_pkg::CMD_SUB: r = x - y;
                        rfae_pkg::CMD_MUL: r = x * y;
                        // min / -1 wraps; min % -1 is 0
                        rfae_pkg::CMD_DIV: begin
                            if (x == 32'h8000_0000 && y == 32'hFFFF_FFFF) r = x;
                            else r = $signed(x) / $signed(y);
                        end
                        rfae_pkg::CMD_MOD: begin
                            if (y == 32'hFFFF_FFFF) r = 32'd0;
                            else r = $signed(x) % $signed(y);
                        end
                        rfae_pkg::CMD_AND: r = x & y;
                        rfae_pkg::CMD_OR:  r = x | y;
                        default: r = x ^ y;
                    endcase
                    write_reg(d, r);
                end
            end
            default: ;
        endcase
    endfunction

    task automatic send_instr(logic [3:0] op, logic [4:0] d, logic [4:0] sa, logic [4:0] sb,
                              logic three, logic [31:0] imm);
        while ($urandom_range(99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {4'd0, imm, three, sb, sa, d, op};
        // tready only moves at rising edges, so its level at the falling edge
        // is what the next rising edge sees
        @(negedge aclk);
        while (!s_axis_tready) @(negedge aclk);
        @(posedge aclk);
        execute_instr(op, d, sa, sb, three, imm);
    endtask

    task automatic send_gap();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic drain();
        send_gap();
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
    endtask

    function automatic logic [31:0] rand_value();
        case ($urandom_range(5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'hFFFF_FFFF;
            3: return $urandom_range(4);
            4: return -$urandom_range(4);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [4:0] rand_idx();
        return ($urandom_range(19) == 0) ? 5'($urandom_range(26, 31)) : 5'($urandom_range(7));
    endfunction

    // receiver: random stalls, plus a held-off stretch when requested
    always @(posedge aclk) begin
        if (!aresetn || sink_hold) m_axis_tready <= 1'b0;
        else m_axis_tready <= ($urandom_range(99) >= idle_pct);
    end

    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result value=%h status=%b", m_axis_tdata, m_axis_tuser);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (m_axis_tdata !== want.value) begin
                    $error("value expected %h actual %h", want.value, m_axis_tdata);
                    fail_count++;
                end
                if (m_axis_tuser !== want.status) begin
                    $error("status expected %b actual %b", want.status, m_axis_tuser);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic test_directed();
        send_instr(rfae_pkg::CMD_OUT, 0, 0, 0, 0, 0);
        send_instr(rfae_pkg::CMD_LOAD, 0, 0, 0, 1, 32'h8000_0000);
        send_instr(rfae_pkg::CMD_LOAD, 1, 0, 0, 0, 32'hFFFF_FFFF);
        send_instr(rfae_pkg::CMD_LOAD, 25, 0, 0, 0, 32'h7FFF_FFFF);
        send_instr(rfae_pkg::CMD_DIV, 2, 0, 1, 1, 0);
        send_instr(rfae_pkg::CMD_MOD, 3, 0, 1, 1, 0);
        send_instr(rfae_pkg::CMD_OUT, 2, 0, 0, 0, 0);
        send_instr(rfae_pkg::CMD_OUT, 3, 0, 0, 0, 0);
        send_instr(rfae_pkg::CMD_DIV, 25, 4, 0, 0, 0);
        send_instr(rfae_pkg::CMD_MOD, 5, 25, 31, 1, 0);
        send_instr(rfae_pkg::CMD_ADD, 4, 25, 1, 1, 0);
        send_instr(rfae_pkg::CMD_SUB, 5, 0, 25, 1, 0);
        send_instr(rfae_pkg::CMD_MUL, 25, 25, 0, 0, 0);
        send_instr(rfae_pkg::CMD_AND, 6, 1, 25, 1, 0);
        send_instr(rfae_pkg::CMD_OR, 7, 0, 25, 1, 0);
        send_instr(rfae_pkg::CMD_XOR, 7, 1, 0, 0, 0);
        send_instr(rfae_pkg::CMD_MOVE, 8, 25, 0, 1, 0);
        send_instr(rfae_pkg::CMD_XCHG, 8, 0, 0, 0, 0);
        send_instr(rfae_pkg::CMD_XCHG, 1, 1, 0, 0, 0);
        send_instr(rfae_pkg::CMD_XCHG, 2, 30, 0, 0, 0);
        send_instr(rfae_pkg::CMD_LOAD, 31, 31, 31, 1, 32'h1234_5678);
        send_instr(rfae_pkg::CMD_OUT, 31, 0, 0, 0, 0);
        send_instr(4'd12, 0, 0, 0, 0, 0);
        send_instr(4'd15, 31, 31, 31, 1, 32'hFFFF_FFFF);
        send_instr(rfae_pkg::CMD_OUT, 8, 0, 0, 0, 0);
        drain();
    endtask

    task automatic send_random(int count);
        logic [3:0] op;
        repeat (count) begin
            op = ($urandom_range(29) == 0) ? 4'($urandom_range(12, 15)) : 4'($urandom_range(11));
            send_instr(op, rand_idx(), rand_idx(), rand_idx(), 1'($urandom),
                       (op == rfae_pkg::CMD_LOAD) ? rand_value() : $urandom);
        end
    endtask

    task automatic test_random();
        send_random(200);
        idle_pct = 0;
        send_random(100);
        idle_pct = 36;
        send_random(150);
        drain();
    endtask

    task automatic test_backpressure();
        fork
            begin
                sink_hold = 1'b1;
                repeat (400) @(posedge aclk);
                sink_hold = 1'b0;
            end
            repeat (12) send_instr(rfae_pkg::CMD_OUT, 5'($urandom_range(25)), 0, 0, 0, 0);
        join
        drain();
        send_random(30);
        drain();
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        foreach (shadow_regs[i]) shadow_regs[i] = '0;
        test_directed();
        test_random();
        test_backpressure();
        if (fail_count == 0) $display("TB_OK");
        else $display("TB_ERROR");
        $finish;
    end
endmodule
